[hw/rtl/deq_pkg.sv]
// Shared types and constants for the deque engine.
package deq_pkg;
  localparam int DEQ_DEPTH = 64;
  localparam int VAL_W = 32;
  localparam int OP_W = 4;
  localparam int POS_W = 6;
  localparam int LEN_W = 7;

  localparam logic [OP_W-1:0] OP_PUSHF = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSHB = 4'd1;
  localparam logic [OP_W-1:0] OP_POPF = 4'd2;
  localparam logic [OP_W-1:0] OP_POPB = 4'd3;
  localparam logic [OP_W-1:0] OP_ERASE = 4'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd5;
  localparam logic [OP_W-1:0] OP_REVERSE = 4'd6;
  localparam logic [OP_W-1:0] OP_SORT = 4'd7;
  localparam logic [OP_W-1:0] OP_RESIZE = 4'd8;
  localparam logic [OP_W-1:0] OP_ASSIGN = 4'd9;
  localparam logic [OP_W-1:0] OP_STATUS = 4'd10;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,     // waiting for a request
    S_EXEC,     // pushes, truncation, pick the walk
    S_FETCH,    // read the popped or erased element
    S_ERASE,    // close up after erase
    S_SORT_OUT, // outer insertion-sort step: fetch key
    S_SORT_IN,  // inner step: compare and shift
    S_FILL,     // fill at the rear
    S_FRONT,    // read front for the result
    S_BACK,     // read back for the result
    S_DONE      // present the result
  } state_t;
endpackage

[hw/rtl/double_ended_queue_engine_top.sv]
// Deque engine: ring store with one read and one write port under a small sequencer.
// Pops and erase first read the removed element, and erase then closes up the gap
// one element at a time; resize truncates or fills at the rear, assign clears and
// fills; sort runs an insertion sort. Each request ends with the front and back reads.
// An empty result skips both reads. One request at a time: the next is taken in the
// cycle after done at the earliest. Sync reset empties the deque, not the store.
module double_ended_queue_engine_top import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op,
  input  logic signed [VAL_W-1:0] value,
  input  logic [POS_W-1:0]      position,
  input  logic [LEN_W-1:0]      length,
  output logic                  done,
  output logic signed [VAL_W-1:0] removed_value,
  output logic [1:0]            status,
  output logic [LEN_W-1:0]      element_count,
  output logic signed [VAL_W-1:0] front_value,
  output logic signed [VAL_W-1:0] back_value,
  output logic                  is_empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);

  state_t state, state_next;

  logic [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd;

  logic [AW-1:0] fp;
  logic [CW-1:0] cnt;
  logic          rev;

  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;
  logic [CW-1:0]    tgt;
  logic [1:0]       st_r, st_in;
  logic [VAL_W-1:0] rem_r, front_r, back_r;
  logic signed [VAL_W-1:0] key;
  logic [CW-1:0]    i, j;

  // memory port
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [VAL_W-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    wrap = (s >= DEPTH_X) ? AW'(s - DEPTH_X) : AW'(s);
  endfunction

  // slot of logical index k (k below the count)
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] c,
                                         input logic r, input logic [CW-1:0] k);
    logic [CW-1:0] off;
    off = r ? c - k - CW'(1) : k;
    slot = wrap({{(CW + 1 - AW){1'b0}}, f} + {1'b0, off});
  endfunction

  logic          accept;
  logic          is_push, is_pop, is_size_op, push_low, pop_low, key_gt;
  logic [LW-1:0] len_ext;
  logic [CW:0]   fp_ext;
  logic [AW-1:0] fp_inc, fp_dec, ring_tail;

  assign accept = start && !busy;
  assign len_ext = LW'(length);
  assign fp_ext = {{(CW + 1 - AW){1'b0}}, fp};
  assign is_push = (op_r == OP_PUSHF) || (op_r == OP_PUSHB);
  assign is_pop = (op_r == OP_POPF) || (op_r == OP_POPB);
  assign is_size_op = (op_r == OP_RESIZE) || (op_r == OP_ASSIGN);
  // storage-low end moves: front of a forward ring, back of a reversed one
  assign push_low = (op_r == OP_PUSHF) != rev;
  assign pop_low = (op_r == OP_POPF) != rev;
  assign key_gt = rd > key;
  assign fp_inc = (fp == LAST) ? '0 : fp + AW'(1);
  assign fp_dec = (fp == '0) ? LAST : fp - AW'(1);
  assign ring_tail = wrap(fp_ext + {1'b0, cnt});

  always_comb begin
    st_in = ST_OK;
    unique case (op) inside
      OP_PUSHF, OP_PUSHB: if (cnt == FULL_CNT) st_in = ST_FULL;
      OP_POPF, OP_POPB: if (cnt == '0) st_in = ST_EMPTY;
      OP_ERASE: if (LW'(position) >= LW'(cnt)) st_in = ST_RANGE;
      OP_RESIZE, OP_ASSIGN: if (len_ext > LW'(DEPTH)) st_in = ST_FULL;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: begin
        if ((is_pop || op_r == OP_ERASE) && st_r == ST_OK) state_next = S_FETCH;
        else if (op_r == OP_SORT) state_next = S_SORT_OUT;
        else if (is_size_op && cnt < tgt) state_next = S_FILL;
        else state_next = S_FRONT;
      end
      S_FETCH: if (ph) state_next = (op_r == OP_ERASE) ? S_ERASE : S_FRONT;
      S_ERASE: if (i + CW'(1) >= cnt) state_next = S_FRONT;
      S_SORT_OUT: begin
        if (i >= cnt) state_next = S_FRONT;
        else if (ph) state_next = S_SORT_IN;
      end
      S_SORT_IN: if ((!ph && j == '0) || (ph && !key_gt)) state_next = S_SORT_OUT;
      S_FILL: if (cnt + CW'(1) >= tgt) state_next = S_FRONT;
      S_FRONT: begin
        if (cnt == '0) state_next = S_DONE;
        else if (ph) state_next = S_BACK;
      end
      S_BACK: if (ph) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sub-phase of a read step: 0 = issue read, 1 = data valid
  logic ph;

  // memory control
  always_comb begin
    we = 1'b0; wa = '0; wd = val_r; ra = '0;
    unique case (state)
      S_EXEC: if (is_push && st_r == ST_OK) begin
        we = 1'b1; wa = push_low ? fp_dec : ring_tail;
      end
      S_FETCH: begin
        if (op_r == OP_ERASE) ra = slot(fp, cnt, rev, CW'(pos_r));
        else if (op_r == OP_POPF) ra = slot(fp, cnt, rev, '0);
        else ra = slot(fp, cnt, rev, cnt - CW'(1));
      end
      S_ERASE: if (i + CW'(1) < cnt) begin
        ra = slot(fp, cnt, rev, i + CW'(1));
        we = ph; wa = slot(fp, cnt, rev, i); wd = rd;
      end
      S_SORT_OUT: if (i < cnt) ra = slot(fp, cnt, rev, i);
      S_SORT_IN: begin
        if (!ph) begin
          if (j == '0) begin
            we = 1'b1; wa = slot(fp, cnt, rev, '0); wd = key;
          end else ra = slot(fp, cnt, rev, j - CW'(1));
        end else begin
          we = 1'b1; wa = slot(fp, cnt, rev, j); wd = key_gt ? rd : key;
        end
      end
      S_FILL: begin we = 1'b1; wa = rev ? fp_dec : ring_tail; end
      S_FRONT: if (cnt != '0) ra = slot(fp, cnt, rev, '0);
      S_BACK: ra = slot(fp, cnt, rev, cnt - CW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fp <= '0; cnt <= '0; rev <= 1'b0; ph <= 1'b0;
      op_r <= OP_STATUS; val_r <= '0; pos_r <= '0; tgt <= '0; st_r <= ST_OK;
      rem_r <= '1; front_r <= '0; back_r <= '0; key <= '0; i <= '0; j <= '0;
    end else begin
      state <= state_next;
      ph <= (state != state_next) ? 1'b0 : ~ph;
      unique case (state)
        S_IDLE: if (accept) begin
          op_r <= op; val_r <= value; pos_r <= position;
          rem_r <= '1; st_r <= st_in;
          tgt <= (len_ext > LW'(DEPTH)) ? FULL_CNT : CW'(length);
          if (op == OP_CLEAR || op == OP_ASSIGN) begin
            cnt <= '0; fp <= '0; rev <= 1'b0;
          end else if (op == OP_REVERSE) rev <= ~rev;
        end
        S_EXEC: begin
          if (is_push && st_r == ST_OK) begin
            if (push_low) fp <= fp_dec;
            cnt <= cnt + CW'(1);
          end
          if (op_r == OP_SORT) i <= CW'(1);
          // truncate from the rear; a reversed ring keeps its rear at fp
          if (op_r == OP_RESIZE && cnt > tgt) begin
            cnt <= tgt;
            if (rev) fp <= wrap(fp_ext + {1'b0, cnt - tgt});
          end
        end
        S_FETCH: if (ph) begin
          rem_r <= rd;
          if (op_r == OP_ERASE) i <= CW'(pos_r);
          else begin
            if (pop_low) fp <= fp_inc;
            cnt <= cnt - CW'(1);
          end
        end
        S_ERASE: begin
          if (i + CW'(1) >= cnt) begin
            cnt <= cnt - CW'(1);
            if (rev) fp <= fp_inc;
          end else if (ph) i <= i + CW'(1);
        end
        S_SORT_OUT: if (i < cnt && ph) begin
          key <= rd; j <= i;
        end
        S_SORT_IN: begin
          if (!ph) begin
            if (j == '0) i <= i + CW'(1);
          end else if (key_gt) j <= j - CW'(1);
          else i <= i + CW'(1);
        end
        S_FILL: begin
          cnt <= cnt + CW'(1);
          if (rev) fp <= fp_dec;
        end
        S_FRONT: if (cnt != '0 && ph) front_r <= rd;
        S_BACK: if (ph) back_r <= rd;
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign removed_value = rem_r;
  assign status = st_r;
  assign element_count = LEN_W'(cnt);
  assign is_empty = (cnt == '0);
  assign front_value = is_empty ? '1 : front_r;
  assign back_value = is_empty ? '1 : back_r;
endmodule

[hw/rtl/deq_checker.sv]
// Port-level assertions for the deque engine, bound to the top level.
module deq_checker import deq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic [1:0] status,
  input logic [LEN_W-1:0] element_count,
  input logic is_empty,
  input logic signed [VAL_W-1:0] front_value
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (element_count == '0)))
    else $error("empty flag mismatch");
  a_front: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (front_value == -1))
    else $error("front of empty deque");
  a_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> is_empty)
    else $error("empty status on a non-empty deque");
endmodule

bind double_ended_queue_engine_top deq_checker u_deq_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .status(status),
  .element_count(element_count), .is_empty(is_empty), .front_value(front_value)
);
